// File: sv/lbps_pkg.sv
`timescale 1ns / 1ps

package lbps_pkg;

  localparam int RomLen = 47;
  localparam int PatMax = 13;

  localparam logic [19:0] PRESS_MAX = 20'hFFFFF;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_SET     = 3'd1;
  localparam logic [2:0] REQ_ON      = 3'd2;
  localparam logic [2:0] REQ_OFF     = 3'd3;
  localparam logic [2:0] REQ_TOGGLE  = 3'd4;
  localparam logic [2:0] REQ_PRESS   = 3'd5;
  localparam logic [2:0] REQ_RELEASE = 3'd6;
  localparam logic [2:0] REQ_STATUS  = 3'd7;

  localparam logic [3:0] MODE_FIXED  = 4'd0;
  localparam logic [3:0] MODE_OFF    = 4'd1;
  localparam logic [3:0] MODE_ON     = 4'd2;
  localparam logic [3:0] MODE_SLOW   = 4'd8;
  localparam logic [3:0] MODE_MEDIUM = 4'd9;
  localparam logic [3:0] MODE_FAST   = 4'd10;

  localparam logic [2:0] REG_INITIAL_PATTERN = 3'd0;
  localparam logic [2:0] REG_ACTIVE_HIGH     = 3'd1;
  localparam logic [2:0] REG_STATUS_LED      = 3'd2;
  localparam logic [2:0] REG_MED_PRESS_MS    = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS_MS   = 3'd4;

  localparam logic [1:0] LINK_CONNECTED    = 2'd0;
  localparam logic [1:0] LINK_STARTING     = 2'd1;
  localparam logic [1:0] LINK_DISCONNECTED = 2'd2;
  localparam logic [1:0] LINK_STOPPED      = 2'd3;

  typedef logic signed [7:0] rom_entry_t;

  function automatic rom_entry_t rom_entry(input logic [5:0] idx);
    rom_entry_t e;
    case (idx)
      6'd0:  e = 8'sd0;
      6'd1:  e = 8'sd126;
      6'd2:  e = -8'sd1;
      6'd3:  e = 8'sd127;
      6'd4:  e = -8'sd1;
      6'd5:  e = 8'sd15;
      6'd6:  e = 8'sd120;
      6'd7:  e = 8'sd120;
      6'd8:  e = 8'sd120;
      6'd9:  e = -8'sd4;
      6'd10: e = 8'sd15;
      6'd11: e = 8'sd100;
      6'd12: e = -8'sd2;
      6'd13: e = 8'sd14;
      6'd14: e = 8'sd121;
      6'd15: e = 8'sd121;
      6'd16: e = 8'sd121;
      6'd17: e = -8'sd4;
      6'd18: e = 8'sd14;
      6'd19: e = 8'sd101;
      6'd20: e = -8'sd2;
      6'd21: e = 8'sd31;
      6'd22: e = 8'sd80;
      6'd23: e = 8'sd31;
      6'd24: e = 8'sd80;
      6'd25: e = 8'sd80;
      6'd26: e = -8'sd5;
      6'd27: e = 8'sd101;
      6'd28: e = 8'sd101;
      6'd29: e = 8'sd100;
      6'd30: e = 8'sd100;
      6'd31: e = -8'sd4;
      6'd32: e = 8'sd81;
      6'd33: e = 8'sd80;
      6'd34: e = -8'sd2;
      6'd35: e = 8'sd21;
      6'd36: e = 8'sd20;
      6'd37: e = -8'sd2;
      6'd38: e = 8'sd11;
      6'd39: e = 8'sd10;
      6'd40: e = -8'sd2;
      6'd41: e = 8'sd41;
      6'd42: e = -8'sd42;
      6'd43: e = 8'sd31;
      6'd44: e = 8'sd20;
      6'd45: e = 8'sd31;
      6'd46: e = -8'sd46;
      default: e = 8'sd0;
    endcase
    return e;
  endfunction

  function automatic logic [5:0] start_of(input logic [3:0] pat);
    logic [5:0] s;
    case (pat)
      4'd0:  s = 6'd0;
      4'd1:  s = 6'd1;
      4'd2:  s = 6'd3;
      4'd3:  s = 6'd5;
      4'd4:  s = 6'd10;
      4'd5:  s = 6'd13;
      4'd6:  s = 6'd18;
      4'd7:  s = 6'd21;
      4'd8:  s = 6'd27;
      4'd9:  s = 6'd32;
      4'd10: s = 6'd35;
      4'd11: s = 6'd38;
      4'd12: s = 6'd41;
      4'd13: s = 6'd43;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

endpackage

// File: sv/led_blink_pattern_sequencer_core.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    req_type, pattern, link_state
// out      out_valid / out_ready  led_level, mode_sel, rejected
// cfg      APB psel/penable       paddr, pwdata, prdata (pready tied high)
//
// One item per cycle: each transfer fills the result register and, with no cfg write
// alongside, updates the state in one pass (two chained pattern ROM reads on a jump).
// in_ready is high while the result register is empty or being drained.
// Synchronous reset loads pattern 2 with its ROM offset and clears timers.
// A stall on out holds the result; in stalls only while that result waits.

module led_blink_pattern_sequencer_core #(
  parameter int MS_PER_UNIT = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  pattern,
  input  logic [1:0]  link_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        led_level,
  output logic [3:0]  mode_sel,
  output logic        rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbps_pkg::*;

  localparam int RW = $clog2(63 * MS_PER_UNIT + 1);

  logic [3:0]    initial_pattern;
  logic          active_high;
  logic          status_led;
  logic [15:0]   med_press_ms;
  logic [15:0]   long_press_ms;

  logic [3:0]    mode_reg;
  logic [5:0]    step_ptr;
  logic [RW-1:0] remaining_ms;
  logic          pressed;
  logic [19:0]   press_ms;
  logic          level_reg;

  logic [3:0]    mode_next;
  logic [5:0]    step_ptr_next;
  logic [RW-1:0] remaining_ms_next;
  logic          pressed_next;
  logic [19:0]   press_ms_next;
  logic          level_next;
  logic          rejected_next;

  logic          in_xfer;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  logic [19:0]   press_inc;
  logic [3:0]    auto_mode;
  logic          auto_change;
  logic [5:0]    t_ptr;
  logic [RW-1:0] t_rem;
  logic [RW-1:0] t_rem_dec;
  logic [5:0]    p0;
  logic [5:0]    p1;
  rom_entry_t    d0;
  rom_entry_t    d1;
  rom_entry_t    d_step;
  logic [7:0]    neg_d0;
  logic [5:0]    back;
  logic          step_level;
  logic [RW-1:0] step_rem;
  logic [5:0]    step_ptr_adv;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      REG_INITIAL_PATTERN: prdata = {28'd0, initial_pattern};
      REG_ACTIVE_HIGH:     prdata = {31'd0, active_high};
      REG_STATUS_LED:      prdata = {31'd0, status_led};
      REG_MED_PRESS_MS:    prdata = {16'd0, med_press_ms};
      REG_LONG_PRESS_MS:   prdata = {16'd0, long_press_ms};
      default:             prdata = 32'd0;
    endcase
  end

  assign press_inc = (pressed && press_ms != PRESS_MAX) ? press_ms + 20'd1 : press_ms;

  always_comb begin
    auto_mode = mode_reg;
    if (pressed) begin
      if (press_inc > {3'd0, long_press_ms, 1'b0}) begin
        auto_mode = MODE_ON;
      end else if (press_inc > {4'd0, long_press_ms}) begin
        auto_mode = MODE_FAST;
      end else if (press_inc > {4'd0, med_press_ms}) begin
        auto_mode = MODE_MEDIUM;
      end
    end else begin
      unique case (link_state)
        LINK_CONNECTED:    auto_mode = MODE_OFF;
        LINK_STARTING:     auto_mode = MODE_MEDIUM;
        LINK_DISCONNECTED: auto_mode = MODE_SLOW;
        LINK_STOPPED:      auto_mode = MODE_ON;
        default:           auto_mode = MODE_ON;
      endcase
    end
  end

  assign auto_change = status_led && (mode_reg != MODE_FIXED) && (auto_mode != mode_reg);
  assign t_ptr       = auto_change ? start_of(auto_mode) : step_ptr;
  assign t_rem       = auto_change ? '0 : remaining_ms;
  assign t_rem_dec   = (t_rem != '0) ? t_rem - RW'(1) : '0;

  // resolve a jump back, then read the step it lands on
  assign p0     = (t_ptr >= 6'(RomLen)) ? 6'd0 : t_ptr;
  assign d0     = rom_entry(p0);
  assign neg_d0 = 8'(-d0);
  assign back   = neg_d0[5:0];
  assign p1     = (d0 < 0) ? ((back > p0) ? 6'd0 : p0 - back) : p0;
  assign d1     = rom_entry(p1);
  assign d_step = (d1 < 0) ? 8'sd0 : d1;

  assign step_level   = (d_step[0] == active_high);
  assign step_rem     = RW'(d_step[6:1]) * RW'(MS_PER_UNIT);
  assign step_ptr_adv = p1 + 6'd1;

  always_comb begin
    mode_next         = mode_reg;
    step_ptr_next     = step_ptr;
    remaining_ms_next = remaining_ms;
    pressed_next      = pressed;
    press_ms_next     = press_ms;
    level_next        = level_reg;
    rejected_next     = 1'b0;
    unique case (req_type)
      REQ_TICK: begin
        press_ms_next = press_inc;
        if (auto_change) begin
          mode_next = auto_mode;
        end
        if (t_rem_dec == '0) begin
          level_next        = step_level;
          remaining_ms_next = step_rem;
          step_ptr_next     = step_ptr_adv;
        end else begin
          remaining_ms_next = t_rem_dec;
          step_ptr_next     = t_ptr;
        end
      end
      REQ_SET: begin
        if (pattern <= 4'(PatMax)) begin
          mode_next         = MODE_FIXED;
          step_ptr_next     = start_of(pattern);
          remaining_ms_next = '0;
        end
      end
      REQ_ON: begin
        mode_next         = MODE_ON;
        step_ptr_next     = start_of(MODE_ON);
        remaining_ms_next = '0;
      end
      REQ_OFF: begin
        mode_next         = MODE_OFF;
        step_ptr_next     = start_of(MODE_OFF);
        remaining_ms_next = '0;
      end
      REQ_TOGGLE: begin
        if (mode_reg == MODE_ON) begin
          mode_next         = MODE_OFF;
          step_ptr_next     = start_of(MODE_OFF);
          remaining_ms_next = '0;
        end else if (mode_reg == MODE_OFF) begin
          mode_next         = MODE_ON;
          step_ptr_next     = start_of(MODE_ON);
          remaining_ms_next = '0;
        end else begin
          rejected_next = 1'b1;
        end
      end
      REQ_PRESS: begin
        pressed_next  = 1'b1;
        press_ms_next = '0;
      end
      REQ_RELEASE: begin
        pressed_next  = 1'b0;
        press_ms_next = '0;
      end
      REQ_STATUS: begin
        if (pattern == 4'd0) begin
          mode_next     = MODE_ON;
          step_ptr_next = start_of(MODE_ON);
        end else if (pattern <= 4'(PatMax)) begin
          mode_next     = MODE_FIXED;
          step_ptr_next = start_of(pattern);
        end
      end
      default: begin
        rejected_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_pattern <= 4'd2;
      active_high     <= 1'b1;
      status_led      <= 1'b0;
      med_press_ms    <= 16'd500;
      long_press_ms   <= 16'd2000;
      mode_reg        <= 4'd2;
      step_ptr        <= start_of(4'd2);
      remaining_ms    <= '0;
      pressed         <= 1'b0;
      press_ms        <= '0;
      level_reg       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_INITIAL_PATTERN: begin
            if (pwdata[3:0] <= 4'(PatMax)) begin
              initial_pattern <= pwdata[3:0];
              mode_reg        <= pwdata[3:0];
              step_ptr        <= start_of(pwdata[3:0]);
              remaining_ms    <= '0;
            end
          end
          REG_ACTIVE_HIGH:   active_high   <= pwdata[0];
          REG_STATUS_LED:    status_led    <= pwdata[0];
          REG_MED_PRESS_MS:  med_press_ms  <= pwdata[15:0];
          REG_LONG_PRESS_MS: long_press_ms <= pwdata[15:0];
          default: begin
          end
        endcase
      end else if (in_xfer) begin
        mode_reg     <= mode_next;
        step_ptr     <= step_ptr_next;
        remaining_ms <= remaining_ms_next;
        pressed      <= pressed_next;
        press_ms     <= press_ms_next;
        level_reg    <= level_next;
      end
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      led_level <= level_next;
      mode_sel  <= mode_next;
      rejected  <= rejected_next;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lbps_pkg::*;

  localparam int MsPerUnit = 2;

  typedef struct packed {
    logic       level;
    logic [3:0] mode;
    logic       rej;
  } led_state_t;

  class blink_scoreboard;
    byte        step_rom[RomLen];
    logic [5:0] start_idx[PatMax + 1];
    logic [3:0] init_pat;
    logic [3:0] mode;
    logic       act_high;
    logic       status_en;
    logic       pressed;
    logic       level;
    logic [15:0] med_ms;
    logic [15:0] long_ms;
    logic [19:0] press_ms;
    logic [5:0] ptr;
    int         remaining;
    led_state_t led_states_due[$];
    int         errors;
    int         requests;
    int         rejects;

    function new();
      step_rom = '{0, 126, -1, 127, -1, 15, 120, 120, 120, -4, 15, 100, -2,
                   14, 121, 121, 121, -4, 14, 101, -2, 31, 80, 31, 80, 80, -5,
                   101, 101, 100, 100, -4, 81, 80, -2, 21, 20, -2, 11, 10, -2,
                   41, -42, 31, 20, 31, -46};
      start_idx = '{6'd0, 6'd1, 6'd3, 6'd5, 6'd10, 6'd13, 6'd18, 6'd21, 6'd27,
                    6'd32, 6'd35, 6'd38, 6'd41, 6'd43};
      init_pat  = 4'd2;
      act_high  = 1'b1;
      status_en = 1'b0;
      med_ms    = 16'd500;
      long_ms   = 16'd2000;
      pressed   = 1'b0;
      press_ms  = '0;
      level     = 1'b0;
      errors    = 0;
      requests  = 0;
      rejects   = 0;
      load_pattern(init_pat, init_pat, 1'b1);
    endfunction

    function void load_pattern(logic [3:0] m, logic [3:0] sel, bit clear_timer);
      mode = m;
      ptr  = start_idx[sel];
      if (clear_timer) remaining = 0;
    endfunction

    function void take_step();
      int p;
      int d;
      int back;
      p = ptr;
      if (p >= RomLen) p = 0;
      d = step_rom[p];
      if (d < 0) begin
        back = -d;
        p = (back > p) ? 0 : p - back;
        d = step_rom[p];
        if (d < 0) d = 0;
      end
      level     = (d[0] == act_high);
      remaining = (d >> 1) * MsPerUnit;
      ptr       = 6'(p + 1);
    endfunction

    function void apply_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_INITIAL_PATTERN: begin
          if (val[3:0] <= PatMax) begin
            init_pat = val[3:0];
            load_pattern(val[3:0], val[3:0], 1'b1);
          end
        end
        REG_ACTIVE_HIGH:   act_high  = val[0];
        REG_STATUS_LED:    status_en = val[0];
        REG_MED_PRESS_MS:  med_ms    = val[15:0];
        REG_LONG_PRESS_MS: long_ms   = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [2:0] rq, logic [3:0] pt, logic [1:0] lk);
      logic [3:0] pick;
      bit         rej;
      rej = 1'b0;
      requests++;
      case (rq)
        REQ_TICK: begin
          if (pressed && press_ms != PRESS_MAX) press_ms++;
          if (status_en && mode != MODE_FIXED) begin
            pick = mode;
            if (pressed) begin
              if (int'(press_ms) > 2 * int'(long_ms)) pick = MODE_ON;
              else if (int'(press_ms) > int'(long_ms)) pick = MODE_FAST;
              else if (int'(press_ms) > int'(med_ms)) pick = MODE_MEDIUM;
            end else begin
              case (lk)
                LINK_CONNECTED:    pick = MODE_OFF;
                LINK_STARTING:     pick = MODE_MEDIUM;
                LINK_DISCONNECTED: pick = MODE_SLOW;
                default:           pick = MODE_ON;
              endcase
            end
            if (pick != mode) load_pattern(pick, pick, 1'b1);
          end
          if (remaining > 0) remaining--;
          if (remaining == 0) take_step();
        end
        REQ_SET: if (pt <= PatMax) load_pattern(MODE_FIXED, pt, 1'b1);
        REQ_ON:  load_pattern(MODE_ON, MODE_ON, 1'b1);
        REQ_OFF: load_pattern(MODE_OFF, MODE_OFF, 1'b1);
        REQ_TOGGLE: begin
          if (mode == MODE_ON) load_pattern(MODE_OFF, MODE_OFF, 1'b1);
          else if (mode == MODE_OFF) load_pattern(MODE_ON, MODE_ON, 1'b1);
          else rej = 1'b1;
        end
        REQ_PRESS: begin
          pressed  = 1'b1;
          press_ms = '0;
        end
        REQ_RELEASE: begin
          pressed  = 1'b0;
          press_ms = '0;
        end
        default: begin
          if (pt == 4'd0) load_pattern(MODE_ON, MODE_ON, 1'b0);
          else if (pt <= PatMax) load_pattern(MODE_FIXED, pt, 1'b0);
        end
      endcase
      if (rej) rejects++;
      led_states_due.push_back('{level: level, mode: mode, rej: rej});
    endfunction

    function void check_result(logic lv, logic [3:0] md, logic rj);
      led_state_t want;
      if (led_states_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due: led_level %0d mode_sel %0d rejected %0d",
                 $time, lv, md, rj);
        return;
      end
      want = led_states_due.pop_front();
      if (lv !== want.level) begin
        errors++;
        $display("%0t: led_level expected %0d actual %0d", $time, want.level, lv);
      end
      if (md !== want.mode) begin
        errors++;
        $display("%0t: mode_sel expected %0d actual %0d", $time, want.mode, md);
      end
      if (rj !== want.rej) begin
        errors++;
        $display("%0t: rejected expected %0d actual %0d", $time, want.rej, rj);
      end
    endfunction

    function int pending();
      return led_states_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [3:0]  pattern;
  logic [1:0]  link_state;
  logic        out_valid;
  logic        out_ready;
  logic        led_level;
  logic [3:0]  mode_sel;
  logic        rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  blink_scoreboard sb;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_left;
  logic [1:0]  link_now;

  led_blink_pattern_sequencer_core #(
    .MS_PER_UNIT(MsPerUnit)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .pattern   (pattern),
    .link_state(link_state),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_level (led_level),
    .mode_sel  (mode_sel),
    .rejected  (rejected),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: hold off while hold_left runs down, else stall at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(led_level, mode_sel, rejected);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [2:0] rq, input logic [3:0] pt, input logic [1:0] lk);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    pattern    <= pt;
    link_state <= lk;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq, pt, lk);
  endtask

  task automatic send_random(input int count);
    int         k;
    int         roll;
    logic [2:0] rq;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 75) rq = REQ_TICK;
      else if (roll < 79) rq = REQ_PRESS;
      else if (roll < 83) rq = REQ_RELEASE;
      else if (roll < 87) rq = REQ_SET;
      else if (roll < 90) rq = REQ_ON;
      else if (roll < 93) rq = REQ_OFF;
      else if (roll < 97) rq = REQ_TOGGLE;
      else rq = REQ_STATUS;
      if ($urandom_range(19) == 0) link_now = 2'($urandom_range(3));
      send_item(rq, 4'($urandom_range(15)), link_now);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.apply_reg(idx, val);
  endtask

  task automatic set_config(input logic [31:0] ip, input logic [31:0] ah,
                            input logic [31:0] st, input logic [31:0] med,
                            input logic [31:0] lng);
    write_reg(REG_INITIAL_PATTERN, ip);
    write_reg(REG_ACTIVE_HIGH, ah);
    write_reg(REG_STATUS_LED, st);
    write_reg(REG_MED_PRESS_MS, med);
    write_reg(REG_LONG_PRESS_MS, lng);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int ph;
    sb          = new();
    tx_idle_pct = 17;
    rx_idle_pct = 49;
    hold_left   = 0;
    link_now    = LINK_CONNECTED;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_TICK;
    pattern    <= '0;
    link_state <= LINK_CONNECTED;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd15, LINK_STOPPED);
    send_item(REQ_TOGGLE, 4'd0, LINK_STARTING);
    send_item(REQ_TOGGLE, 4'd15, LINK_DISCONNECTED);
    send_item(REQ_OFF, 4'd0, LINK_CONNECTED);
    send_item(REQ_SET, 4'd0, LINK_CONNECTED);
    send_item(REQ_TOGGLE, 4'd0, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_SET, 4'd13, LINK_CONNECTED);
    send_item(REQ_SET, 4'd15, LINK_CONNECTED);
    send_item(REQ_STATUS, 4'd14, LINK_CONNECTED);
    send_item(REQ_STATUS, 4'd0, LINK_CONNECTED);
    send_item(REQ_STATUS, 4'd13, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_STOPPED);
    send_item(REQ_PRESS, 4'd0, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_RELEASE, 4'd0, LINK_CONNECTED);
    send_item(REQ_ON, 4'd0, LINK_CONNECTED);
    send_item(REQ_SET, 4'd12, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);
    send_item(REQ_STATUS, 4'd7, LINK_CONNECTED);
    send_item(REQ_TICK, 4'd0, LINK_CONNECTED);

    for (ph = 0; ph < 6; ph++) begin
      hold_until_drained();
      repeat (3) @(posedge clk);
      if (ph < 2) begin
        tx_idle_pct = 17;
        rx_idle_pct = 49;
      end else if (ph < 4) begin
        tx_idle_pct = 49;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0: set_config(11, 0, 1, 2, 6);
        1: set_config(0, 1, 1, 0, 0);
        2: set_config(13, 1, 0, 65535, 65535);
        3: set_config(15, 0, 1, 10, 20);
        4: set_config($urandom_range(15), $urandom_range(1), $urandom_range(1),
                      $urandom_range(40), $urandom_range(80));
        default: set_config(12, 1, 1, 65535, 0);
      endcase
      send_random(40);
      if (ph == 1) hold_left = 60;
      if (ph == 2) hold_until_drained();
      send_random(80);
    end

    hold_until_drained();
    repeat (5) @(posedge clk);
    $display("Checked %0d LED requests (%0d refused toggles) over six register settings,",
             sb.requests, sb.rejects);
    $display("with sender and receiver stalls, a long output hold-off and a full drain.");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
